// File: sv/ntdh_pkg.sv
package ntdh_pkg;

  localparam int MAX_TARGETS = 1024;
  localparam int COORD_BITS  = 24;

  localparam int IDX_BITS   = $clog2(MAX_TARGETS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DSUM_BITS  = 2 * COORD_BITS + 2;
  localparam int ENTRY_BITS = 3 * COORD_BITS;

  // result field widths
  localparam int DIST_BITS  = 25;
  localparam int HDIFF_BITS = 25;
  localparam int NIDX_BITS  = 10;
  localparam int OUT_BITS   = DIST_BITS + HDIFF_BITS + NIDX_BITS;
  localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
  localparam int OUT_TDATA_BITS = 8 * OUT_BYTES;

  typedef enum logic [1:0] {
    ST_LOADED     = 2'd0,
    ST_QUERY_DONE = 2'd1,
    ST_STORE_FULL = 2'd2,
    ST_NO_TARGETS = 2'd3
  } status_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SQRT = 3'b100
  } state_t;

endpackage

// File: sv/nearest_target_distance_height.sv
// Loads and empty-store queries: the result is staged, then registered on the port; the
// next beat is taken once the staged result moves to the port. Queries: scan N stored
// targets (one memory read per cycle through a 5-stage distance pipeline), then a
// bit-serial square root; s_tready stays low through the scan and the root, and until
// the result has left staging. Reset (rst, synchronous, active high) empties the store and
// sets mode_3d to 1; target memory is not cleared and only written entries are read.
module nearest_target_distance_height (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: mode_3d
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  // input beats
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ntdh_pkg::ENTRY_BITS-1:0]     s_tdata,   // x, y, z
  input  logic                                s_tuser,   // action
  // result beats
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ntdh_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // distance, height_diff,
                                                         // nearest_index, zero pad
  output logic [1:0]                          m_tuser    // status
);

  localparam int C = ntdh_pkg::COORD_BITS;

  // ---------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------
  ntdh_pkg::state_t state;
  logic                          mode_3d;
  logic [ntdh_pkg::CNT_BITS-1:0] count;
  logic [ntdh_pkg::CNT_BITS-1:0] rd_cnt;

  // query point
  logic signed [C-1:0] qx, qy, qz;

  // pending result (skid between the work side and the output register)
  logic                                res_valid;
  ntdh_pkg::status_t                   res_status;
  logic [ntdh_pkg::DIST_BITS-1:0]      res_dist;
  logic [ntdh_pkg::HDIFF_BITS-1:0]     res_hdiff;
  logic [ntdh_pkg::NIDX_BITS-1:0]      res_idx;

  logic s_acc;
  logic is_query;
  logic store_full;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ntdh_pkg::S_IDLE) && !res_valid;
  assign s_acc      = s_tvalid && s_tready;
  assign is_query   = (s_tuser == ntdh_pkg::ACT_QUERY);
  assign store_full = (count >= ntdh_pkg::CNT_BITS'(ntdh_pkg::MAX_TARGETS));

  // ---------------------------------------------------------------
  // target memory: {z, y, x} per entry, registered read
  // ---------------------------------------------------------------
  logic [ntdh_pkg::ENTRY_BITS-1:0] mem [ntdh_pkg::MAX_TARGETS];
  logic [ntdh_pkg::ENTRY_BITS-1:0] mem_q;
  logic                            mem_we;
  logic                            rd_en;

  assign mem_we = s_acc && !is_query && !store_full;
  assign rd_en  = (state == ntdh_pkg::S_SCAN) && (rd_cnt < count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ntdh_pkg::IDX_BITS-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_cnt[ntdh_pkg::IDX_BITS-1:0]];
    end
  end

  // ---------------------------------------------------------------
  // distance pipeline
  // p1: memory data, p2: differences, p3: squares, p4: sum, then compare
  // ---------------------------------------------------------------
  logic p1, p2, p3, p4;
  logic [ntdh_pkg::IDX_BITS-1:0] idx1, idx2, idx3, idx4;
  logic signed [C-1:0] z2, z3, z4;
  logic signed [ntdh_pkg::DIFF_BITS-1:0] dx, dy, dz;
  logic signed [2*ntdh_pkg::DIFF_BITS-1:0] mx, my, mz;
  logic [ntdh_pkg::SQ_BITS-1:0] sqx, sqy, sqz;
  logic [ntdh_pkg::DSUM_BITS-1:0] sum4;

  logic signed [C-1:0] ex, ey, ez;
  assign ex = mem_q[C-1:0];
  assign ey = mem_q[2*C-1:C];
  assign ez = mem_q[3*C-1:2*C];

  assign mx = dx * dx;
  assign my = dy * dy;
  assign mz = dz * dz;

  // best candidate so far
  logic                                 have_best;
  logic [ntdh_pkg::DSUM_BITS-1:0]       best_d;
  logic [ntdh_pkg::IDX_BITS-1:0]        best_idx;
  logic signed [C-1:0]                  best_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
      p4 <= 1'b0;
    end else begin
      p1 <= rd_en;
      p2 <= p1;
      p3 <= p2;
      p4 <= p3;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= rd_cnt[ntdh_pkg::IDX_BITS-1:0];
    // stage 2
    dx   <= ntdh_pkg::DIFF_BITS'(qx) - ntdh_pkg::DIFF_BITS'(ex);
    dy   <= ntdh_pkg::DIFF_BITS'(qy) - ntdh_pkg::DIFF_BITS'(ey);
    dz   <= ntdh_pkg::DIFF_BITS'(qz) - ntdh_pkg::DIFF_BITS'(ez);
    z2   <= ez;
    idx2 <= idx1;
    // stage 3: squares are nonnegative and below 2^(2C)
    sqx  <= mx[ntdh_pkg::SQ_BITS-1:0];
    sqy  <= my[ntdh_pkg::SQ_BITS-1:0];
    sqz  <= mz[ntdh_pkg::SQ_BITS-1:0];
    z3   <= z2;
    idx3 <= idx2;
    // stage 4
    sum4 <= ntdh_pkg::DSUM_BITS'(sqx) + ntdh_pkg::DSUM_BITS'(sqy)
          + (mode_3d ? ntdh_pkg::DSUM_BITS'(sqz) : '0);
    z4   <= z3;
    idx4 <= idx3;
  end

  // strict less-than keeps the earliest target on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (s_acc) begin
      have_best <= 1'b0;
    end else if (p4 && (!have_best || sum4 < best_d)) begin
      have_best <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p4 && (!have_best || sum4 < best_d)) begin
      best_d   <= sum4;
      best_idx <= idx4;
      best_z   <= z4;
    end
  end

  logic scan_done;
  assign scan_done = (state == ntdh_pkg::S_SCAN) && (rd_cnt == count)
                     && !p1 && !p2 && !p3 && !p4;

  // ---------------------------------------------------------------
  // square root: one result bit per cycle, bit walks down by 2
  // ---------------------------------------------------------------
  logic [ntdh_pkg::DSUM_BITS-1:0] sq_n, sq_res, sq_bit;
  logic [ntdh_pkg::DSUM_BITS-1:0] sq_trial, sq_n_next, sq_res_next;
  logic                           sq_take;

  always_comb begin
    sq_trial    = sq_res + sq_bit;
    sq_take     = (sq_n >= sq_trial);
    sq_n_next   = sq_take ? (sq_n - sq_trial) : sq_n;
    sq_res_next = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      sq_n   <= best_d;
      sq_res <= '0;
      sq_bit <= ntdh_pkg::DSUM_BITS'(1) << (ntdh_pkg::DSUM_BITS - 2);
    end else if (state == ntdh_pkg::S_SQRT) begin
      sq_n   <= sq_n_next;
      sq_res <= sq_res_next;
      sq_bit <= sq_bit >> 2;
    end
  end

  logic sq_last;
  assign sq_last = (state == ntdh_pkg::S_SQRT) && sq_bit[0];

  logic signed [ntdh_pkg::HDIFF_BITS-1:0] hdiff;
  assign hdiff = ntdh_pkg::HDIFF_BITS'(qz) - ntdh_pkg::HDIFF_BITS'(best_z);

  // ---------------------------------------------------------------
  // sequencer, store count, mode register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ntdh_pkg::S_IDLE;
      count   <= '0;
      rd_cnt  <= '0;
      mode_3d <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_3d <= cfg_data;
      end
      if (mem_we) begin
        count <= count + 1'b1;
      end
      case (state)
        ntdh_pkg::S_IDLE: begin
          rd_cnt <= '0;
          if (s_acc && is_query && (count != '0)) begin
            state <= ntdh_pkg::S_SCAN;
          end
        end
        ntdh_pkg::S_SCAN: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (scan_done) begin
            state <= ntdh_pkg::S_SQRT;
          end
        end
        ntdh_pkg::S_SQRT: begin
          if (sq_last) begin
            state <= ntdh_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ntdh_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      qx <= s_tdata[C-1:0];
      qy <= s_tdata[2*C-1:C];
      qz <= s_tdata[3*C-1:2*C];
    end
  end

  // ---------------------------------------------------------------
  // result staging and output register
  // ---------------------------------------------------------------
  logic out_load;
  assign out_load = res_valid && (!m_tvalid || m_tready);

  // a query that starts a scan posts its result only at the end of the root
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((s_acc && !(is_query && (count != '0))) || sq_last) begin
      res_valid <= 1'b1;
    end else if (out_load) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      res_dist  <= '0;
      res_hdiff <= '0;
      res_idx   <= '0;
      if (is_query) begin
        res_status <= ntdh_pkg::ST_NO_TARGETS;   // replaced at the end of a scan
      end else if (store_full) begin
        res_status <= ntdh_pkg::ST_STORE_FULL;
      end else begin
        res_status <= ntdh_pkg::ST_LOADED;
        res_idx    <= ntdh_pkg::NIDX_BITS'(count);
      end
    end else if (sq_last) begin
      res_status <= ntdh_pkg::ST_QUERY_DONE;
      res_dist   <= sq_res_next[ntdh_pkg::DIST_BITS-1:0];
      res_hdiff  <= hdiff;
      res_idx    <= ntdh_pkg::NIDX_BITS'(best_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= ntdh_pkg::OUT_TDATA_BITS'({res_idx, res_hdiff, res_dist});
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int    HALF_PERIOD = 5;
  localparam int    CYCLE_LIMIT = 3_000_000;
  localparam int    HOLD_CYCLES = 600;    // long back-pressure stretch
  localparam int    TAIL_CYCLES = 1100;   // > one full-store query
  localparam int    HD_LO       = ntdh_pkg::DIST_BITS;
  localparam int    IX_LO       = ntdh_pkg::DIST_BITS + ntdh_pkg::HDIFF_BITS;
  localparam int    RAND_LOADS  = 45;     // percent of random beats that load

  typedef logic signed [ntdh_pkg::COORD_BITS-1:0] coord_t;

  localparam coord_t CMAX = 24'h7FFFFF;
  localparam coord_t CMIN = 24'h800000;

  // one result beat, status in the top bits
  typedef struct packed {
    ntdh_pkg::status_t                      status;
    logic [ntdh_pkg::DIST_BITS-1:0]         distance;
    logic signed [ntdh_pkg::HDIFF_BITS-1:0] height_diff;
    logic [ntdh_pkg::NIDX_BITS-1:0]         nearest_index;
  } answer_t;

  localparam answer_t NO_ANS = '0;

  typedef enum logic {
    ROW_BEAT = 1'b0,   // send one beat
    ROW_MODE = 1'b1    // wait for idle, then write mode_3d
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              mode;
    ntdh_pkg::action_t act;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic              typed;   // 1: use the answer below, 0: use the local model
    answer_t           want;
  } drill_row_t;

  localparam int DRILL_ROWS = 21;

  // Directed opening. Only obvious answers are typed in; the rest come
  // from the local model.
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    // queries on the empty store
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, 24'sd0, 24'sd0, 24'sd0, 1'b1,
      '{ntdh_pkg::ST_NO_TARGETS, 25'd0, 25'sd0, 10'd0}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMAX, CMIN, CMAX, 1'b1,
      '{ntdh_pkg::ST_NO_TARGETS, 25'd0, 25'sd0, 10'd0}},
    // corner targets, largest distance and height difference both ways
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, CMIN, CMIN, CMIN, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd0}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMAX, CMAX, CMAX, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, CMAX, CMAX, CMAX, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd1}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMAX, CMAX, CMIN, 1'b0, NO_ANS},
    // two targets at equal distance from the origin: first stored wins
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, 24'sd10, 24'sd0, 24'sd0, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd2}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, -24'sd10, 24'sd0, 24'sd0, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd3}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_ANS},
    // duplicate point: the earlier copy stays nearest
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, 24'sd10, 24'sd0, 24'sd0, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd4}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, 24'sd10, 24'sd0, 24'sd5, 1'b0, NO_ANS},
    // target that wins only when z is ignored
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, 24'sd0, 24'sd0, 24'sd5000, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd5}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, 24'sd0, 24'sd3, -24'sd4000, 1'b0, NO_ANS},
    '{ROW_MODE, 1'b0, ntdh_pkg::ACT_LOAD, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, 24'sd0, 24'sd3, -24'sd4000, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMIN, CMIN, CMAX, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMAX, CMAX, CMIN, 1'b0, NO_ANS},
    '{ROW_MODE, 1'b1, ntdh_pkg::ACT_LOAD, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, CMIN, CMAX, 24'sd0, 1'b0, NO_ANS},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_LOAD, CMIN, CMAX, 24'sd1, 1'b1,
      '{ntdh_pkg::ST_LOADED, 25'd0, 25'sd0, 10'd6}},
    '{ROW_BEAT, 1'b0, ntdh_pkg::ACT_QUERY, -24'sd1, -24'sd1, -24'sd1, 1'b0, NO_ANS}
  };

  // DUT ports
  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic                                cfg_data;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [ntdh_pkg::ENTRY_BITS-1:0]     s_tdata;     // x, y, z
  logic                                s_tuser;     // action
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [ntdh_pkg::OUT_TDATA_BITS-1:0] m_tdata;     // distance, height_diff, index, pad
  logic [1:0]                          m_tuser;     // status

  // local copy of the block's state
  coord_t store_x [ntdh_pkg::MAX_TARGETS];
  coord_t store_y [ntdh_pkg::MAX_TARGETS];
  coord_t store_z [ntdh_pkg::MAX_TARGETS];
  int     store_count;
  logic   mode_3d_q;

  answer_t answers_due[$];   // one per accepted beat, oldest first

  int   src_idle_pct;
  int   sink_idle_pct;
  int   mismatches = 0;
  int   beats_out  = 0;
  int   cycles     = 0;
  logic hold_req   = 1'b0;   // toggled to request a long back-pressure stretch
  logic hold_ack   = 1'b0;
  int   hold_left  = 0;

  nearest_target_distance_height u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic longint unsigned sq_diff(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // What the block answers for one beat; updates the local store on loads.
  function automatic answer_t compute_answer(ntdh_pkg::action_t act, coord_t px,
                                             coord_t py, coord_t pz);
    answer_t         a;
    longint unsigned d;
    longint unsigned best_d;
    longint unsigned root;
    longint unsigned trial;
    longint          hd;
    int              best;
    a = NO_ANS;
    if (act == ntdh_pkg::ACT_LOAD) begin
      if (store_count >= ntdh_pkg::MAX_TARGETS) begin
        a.status = ntdh_pkg::ST_STORE_FULL;   // point dropped
      end else begin
        store_x[store_count] = px;
        store_y[store_count] = py;
        store_z[store_count] = pz;
        a.status = ntdh_pkg::ST_LOADED;
        a.nearest_index = store_count[ntdh_pkg::NIDX_BITS-1:0];
        store_count++;
      end
    end else if (store_count == 0) begin
      a.status = ntdh_pkg::ST_NO_TARGETS;
    end else begin
      best   = 0;
      best_d = 0;
      for (int i = 0; i < store_count; i++) begin
        d = sq_diff(px, store_x[i]) + sq_diff(py, store_y[i]);
        if (mode_3d_q)
          d += sq_diff(pz, store_z[i]);
        // strict less-than: the earliest target keeps a tie
        if (i == 0 || d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      // floor square root, one result bit at a time from the top
      root = 0;
      for (int b = ntdh_pkg::DIST_BITS - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= best_d)
          root = trial;
      end
      hd = longint'(pz) - longint'(store_z[best]);
      a.status        = ntdh_pkg::ST_QUERY_DONE;
      a.distance      = root[ntdh_pkg::DIST_BITS-1:0];
      a.height_diff   = hd[ntdh_pkg::HDIFF_BITS-1:0];
      a.nearest_index = best[ntdh_pkg::NIDX_BITS-1:0];
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] result beat %0d, %s: got %0d, want %0d",
             $time, beats_out, what, got, want);
    mismatches++;
  endtask

  function automatic coord_t corner_coord();
    case ($urandom_range(3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Random beat. Coordinates come full range, from a small cluster (ties),
  // from a stored target (duplicates, near misses) or, for loads, from the corners.
  task automatic pick_beat(input int load_pct, output ntdh_pkg::action_t act,
                           output coord_t x, output coord_t y, output coord_t z);
    int k;
    int j;
    k   = (store_count == 0) ? 0 : $urandom_range(store_count - 1);
    act = ($urandom_range(99) < load_pct) ? ntdh_pkg::ACT_LOAD : ntdh_pkg::ACT_QUERY;
    case ($urandom_range(3))
      0: begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
      end
      1: begin
        x = coord_t'($urandom_range(127) - 64);
        y = coord_t'($urandom_range(127) - 64);
        z = coord_t'($urandom_range(127) - 64);
      end
      2: begin
        // loads copy a target's x and z exactly, y and queries land a few units off
        j = (act == ntdh_pkg::ACT_QUERY) ? $urandom_range(16) : 8;
        x = coord_t'(store_x[k] + j - 8);
        y = coord_t'(store_y[k] + $urandom_range(16) - 8);
        z = coord_t'(store_z[k] + j - 8);
      end
      default: begin
        if (act == ntdh_pkg::ACT_QUERY) begin
          // same x, y as a target, any z: 2D and 3D answers part ways
          x = store_x[k];
          y = store_y[k];
          z = coord_t'($urandom);
        end else begin
          x = corner_coord();
          y = corner_coord();
          z = corner_coord();
        end
      end
    endcase
  endtask

  // Present one beat, with random idle cycles first; record the answer
  // once the beat is taken. tvalid stays high into the next call.
  task automatic offer(ntdh_pkg::action_t act, coord_t x, coord_t y, coord_t z,
                       logic typed, answer_t want);
    answer_t model;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    model = compute_answer(act, x, y, z);
    answers_due.push_back(typed ? want : model);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0)
      @(posedge clk);
  endtask

  // mode_3d is only written with nothing in flight
  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_3d_q = m;
  endtask

  task automatic run_phase(int beats, int src_pct, int sink_pct, logic with_hold);
    ntdh_pkg::action_t act;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < beats; n++) begin
      if (with_hold && n == beats / 3)
        hold_req <= ~hold_req;
      pick_beat(RAND_LOADS, act, x, y, z);
      offer(act, x, y, z, 1'b0, NO_ANS);
    end
  endtask

  // Result side ready. A hold request drops tready for a long stretch while the
  // sender keeps offering, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each result beat with the oldest outstanding answer.
  always @(posedge clk) begin : result_check
    answer_t seen;
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = answer_t'({m_tuser, m_tdata[0 +: ntdh_pkg::DIST_BITS],
                        m_tdata[HD_LO +: ntdh_pkg::HDIFF_BITS],
                        m_tdata[IX_LO +: ntdh_pkg::NIDX_BITS]});
      if (answers_due.size() == 0) begin
        report_mismatch("beat with nothing outstanding", longint'(seen.status), 0);
      end else begin
        want = answers_due.pop_front();
        if (seen.status !== want.status)
          report_mismatch("status", longint'(seen.status), longint'(want.status));
        if (seen.distance !== want.distance)
          report_mismatch("distance", longint'(seen.distance), longint'(want.distance));
        if (seen.height_diff !== want.height_diff)
          report_mismatch("height_diff", longint'(seen.height_diff),
                          longint'(want.height_diff));
        if (seen.nearest_index !== want.nearest_index)
          report_mismatch("nearest_index", longint'(seen.nearest_index),
                          longint'(want.nearest_index));
      end
      beats_out++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    ntdh_pkg::action_t act;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = ntdh_pkg::ACT_LOAD;
    store_count = 0;
    mode_3d_q   = 1'b1;      // reset value of the register
    src_idle_pct  = 25;
    sink_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows, under the first idling pattern
    for (int r = 0; r < DRILL_ROWS; r++) begin
      if (DRILL[r].kind == ROW_MODE)
        write_mode(DRILL[r].mode);
      else
        offer(DRILL[r].act, DRILL[r].x, DRILL[r].y, DRILL[r].z, DRILL[r].typed,
              DRILL[r].want);
    end

    // random beats: sender idles lightly / receiver heavily, then the other
    // way round, then no idling plus one long receiver hold
    run_phase(170, 25, 87, 1'b0);
    write_mode(1'b0);
    run_phase(170, 87, 25, 1'b0);
    write_mode(1'b1);
    run_phase(180, 0, 0, 1'b1);

    // Fill the store to the top, then loads that find it full and queries
    // that scan every slot, in both modes.
    while (store_count < ntdh_pkg::MAX_TARGETS) begin
      pick_beat(100, act, x, y, z);
      offer(act, x, y, z, 1'b0, NO_ANS);
    end
    for (int n = 0; n < 13; n++) begin
      if (n == 7)
        write_mode(1'b0);
      if (n == 11)
        write_mode(1'b1);
      pick_beat((n < 3 || n == 10) ? 100 : 0, act, x, y, z);
      offer(act, x, y, z, 1'b0, NO_ANS);
    end

    drain();
    // quiet tail: catches stray result beats
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
sv/ntdh_pkg.sv
sv/nearest_target_distance_height.sv
verif/tb.sv
